// File: hdl/pfs_pkg.sv
package pfs_pkg;

	// Stack and page geometry. PAGE_BYTES must be a power of two.
	localparam int STACK_DEPTH = 4096;
	localparam int PAGE_BYTES  = 4096;

	localparam int ADDR_W     = 64;
	localparam int COUNT_W    = 13;
	localparam int IDX_W      = $clog2(STACK_DEPTH);
	localparam int TOP_W      = $clog2(STACK_DEPTH + 1);
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int PN_W       = ADDR_W - PAGE_SHIFT;

	// Command codes.
	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_ALLOC = 2'd1;
	localparam logic [1:0] CMD_FREE  = 2'd2;
	localparam logic [1:0] CMD_COUNT = 2'd3;

	// Status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_RDATA,
		ST_DONE
	} state_t;

	// Control from the sequencer to the region walker.
	typedef struct packed {
		logic load;
		logic step;
	} walk_ctrl_t;

	// Status from the region walker back to the sequencer.
	typedef struct packed {
		logic              more;
		logic [ADDR_W-1:0] addr;
	} walk_stat_t;

endpackage

// File: hdl/pfs_if.sv
interface pfs_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   cmd;
	logic [pfs_pkg::ADDR_W-1:0]   region_base;
	logic [pfs_pkg::ADDR_W-1:0]   region_length;
	logic                         region_usable;
	logic [pfs_pkg::ADDR_W-1:0]   free_addr;

	modport source (
		output valid, cmd, region_base, region_length, region_usable, free_addr,
		input  ready
	);
	modport sink (
		input  valid, cmd, region_base, region_length, region_usable, free_addr,
		output ready
	);
endinterface

interface pfs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [pfs_pkg::ADDR_W-1:0]    page_addr;
	logic [pfs_pkg::COUNT_W-1:0]   free_count;
	logic [1:0]                    status;

	modport source (
		output valid, page_addr, free_count, status,
		input  ready
	);
	modport sink (
		input  valid, page_addr, free_count, status,
		output ready
	);
endinterface

// File: hdl/page_frame_free_stack.sv
// Page frame allocator built on a last-in first-out stack of free page addresses.
// The req channel carries one command per beat: add a memory-map region, allocate
// a page, free a page, or query the count. The rsp channel returns exactly one
// beat per command with the allocated address, the free count and a status.
// Only one command is in flight: req.ready is high while the sequencer is idle.
// Free, count and an unusable region go from the accepted beat straight to the
// done state; an allocate from a non-empty stack first passes through ST_RDATA for
// the registered read port of the stack memory. req.ready returns in the cycle
// after the result is loaded, so a new command is not taken before then.
// A usable add region command walks the region one page per cycle through the
// incrementer and compare of the region walker; the walk ends early with a full
// status when the stack fills.
// A stalled rsp holds its beat in the output register; a result that is ready
// waits in the done state, with req.ready low, until the register frees.
// Reset clears the stack pointer, so the pool starts empty; the stack memory
// needs no clearing because only entries below the pointer are ever read.

module page_frame_free_stack (
	input  logic      clk,
	input  logic      arst_n,
	pfs_req_if.sink   req,
	pfs_rsp_if.source rsp
);

	pfs_pkg::state_t                    state_q;
	pfs_pkg::state_t                    state_d;
	logic [pfs_pkg::TOP_W-1:0]          top_q;
	logic [pfs_pkg::TOP_W-1:0]          top_d;
	logic [pfs_pkg::TOP_W-1:0]          top_dec;
	logic                               top_empty;
	logic                               top_full;
	logic                               accept;
	logic                               out_load;

	logic [pfs_pkg::ADDR_W-1:0]         res_addr_q;
	logic [pfs_pkg::ADDR_W-1:0]         res_addr_d;
	logic [1:0]                         res_status_q;
	logic [1:0]                         res_status_d;

	logic                               rsp_valid_q;
	logic [pfs_pkg::ADDR_W-1:0]         rsp_addr_q;
	logic [pfs_pkg::COUNT_W-1:0]        rsp_count_q;
	logic [1:0]                         rsp_status_q;

	logic                               ram_we;
	logic [pfs_pkg::IDX_W-1:0]          ram_waddr;
	logic [pfs_pkg::ADDR_W-1:0]         ram_wdata;
	logic [pfs_pkg::IDX_W-1:0]          ram_raddr;
	logic [pfs_pkg::ADDR_W-1:0]         ram_rdata;

	pfs_pkg::walk_ctrl_t                walk_ctrl;
	pfs_pkg::walk_stat_t                walk_stat;

	pfs_ram #(
		.WIDTH (pfs_pkg::ADDR_W),
		.DEPTH (pfs_pkg::STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pfs_region_walk u_walk (
		.clk           (clk),
		.region_base   (req.region_base),
		.region_length (req.region_length),
		.ctrl          (walk_ctrl),
		.stat          (walk_stat)
	);

	// Stack pointer flags.
	assign top_dec   = top_q - pfs_pkg::TOP_W'(1);
	assign top_empty = top_q == '0;
	assign top_full  = top_q == pfs_pkg::TOP_W'(pfs_pkg::STACK_DEPTH);
	assign req.ready = state_q == pfs_pkg::ST_IDLE;
	assign accept    = req.valid && req.ready;
	assign out_load  = (state_q == pfs_pkg::ST_DONE) && (!rsp_valid_q || rsp.ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfs_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req.cmd)
						pfs_pkg::CMD_ADD:   state_d = req.region_usable ?
							pfs_pkg::ST_FILL : pfs_pkg::ST_DONE;
						pfs_pkg::CMD_ALLOC: state_d = top_empty ?
							pfs_pkg::ST_DONE : pfs_pkg::ST_RDATA;
						default:            state_d = pfs_pkg::ST_DONE;
					endcase
				end
			end
			pfs_pkg::ST_FILL: begin
				if (!walk_stat.more || top_full) begin
					state_d = pfs_pkg::ST_DONE;
				end
			end
			pfs_pkg::ST_RDATA: begin
				state_d = pfs_pkg::ST_DONE;
			end
			pfs_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = pfs_pkg::ST_IDLE;
				end
			end
			default: state_d = pfs_pkg::ST_IDLE;
		endcase
	end

	// Datapath control: stack writes, pointer moves and the result.
	always_comb begin
		ram_we         = 1'b0;
		ram_waddr      = top_q[pfs_pkg::IDX_W-1:0];
		ram_wdata      = walk_stat.addr;
		ram_raddr      = top_dec[pfs_pkg::IDX_W-1:0];
		walk_ctrl      = '0;
		top_d          = top_q;
		res_addr_d     = res_addr_q;
		res_status_d   = res_status_q;
		unique case (state_q)
			pfs_pkg::ST_IDLE: begin
				if (accept) begin
					res_addr_d   = '0;
					res_status_d = pfs_pkg::STAT_OK;
					unique case (req.cmd)
						pfs_pkg::CMD_ADD: begin
							walk_ctrl.load = 1'b1;
						end
						pfs_pkg::CMD_ALLOC: begin
							if (top_empty) begin
								res_status_d = pfs_pkg::STAT_EMPTY;
							end else begin
								top_d = top_dec;
							end
						end
						pfs_pkg::CMD_FREE: begin
							if (top_full) begin
								res_status_d = pfs_pkg::STAT_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_wdata = req.free_addr;
								top_d     = top_q + pfs_pkg::TOP_W'(1);
							end
						end
						default: begin
						end
					endcase
				end
			end
			pfs_pkg::ST_FILL: begin
				if (walk_stat.more) begin
					if (top_full) begin
						res_status_d = pfs_pkg::STAT_FULL;
					end else begin
						ram_we         = 1'b1;
						top_d          = top_q + pfs_pkg::TOP_W'(1);
						walk_ctrl.step = 1'b1;
					end
				end
			end
			pfs_pkg::ST_RDATA: begin
				res_addr_d = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfs_pkg::ST_IDLE;
			top_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result and output registers.
	always_ff @(posedge clk) begin
		res_addr_q   <= res_addr_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			rsp_addr_q   <= res_addr_q;
			rsp_count_q  <= pfs_pkg::COUNT_W'(top_q);
			rsp_status_q <= res_status_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.page_addr  = rsp_addr_q;
	assign rsp.free_count = rsp_count_q;
	assign rsp.status     = rsp_status_q;

endmodule

// File: hdl/pfs_ram.sv
module pfs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/pfs_region_walk.sv
module pfs_region_walk (
	input  logic                              clk,
	input  logic [pfs_pkg::ADDR_W-1:0]        region_base,
	input  logic [pfs_pkg::ADDR_W-1:0]        region_length,
	input  pfs_pkg::walk_ctrl_t               ctrl,
	output pfs_pkg::walk_stat_t               stat
);

	logic [pfs_pkg::ADDR_W:0]       sum;
	logic [pfs_pkg::ADDR_W-1:0]     end_addr;
	logic [pfs_pkg::PN_W-1:0]       limit_pn;
	logic [pfs_pkg::PN_W:0]         first_pn;
	logic [pfs_pkg::PN_W:0]         first_q;
	logic [pfs_pkg::PN_W-1:0]       limit_q;

	// Saturate the region end, then round the base up and the end down to pages.
	always_comb begin
		sum      = {1'b0, region_base} + {1'b0, region_length};
		end_addr = sum[pfs_pkg::ADDR_W] ? '1 : sum[pfs_pkg::ADDR_W-1:0];
		limit_pn = end_addr[pfs_pkg::ADDR_W-1:pfs_pkg::PAGE_SHIFT];
		first_pn = {1'b0, region_base[pfs_pkg::ADDR_W-1:pfs_pkg::PAGE_SHIFT]}
			+ (pfs_pkg::PN_W+1)'(|region_base[pfs_pkg::PAGE_SHIFT-1:0]);
	end

	// Page counter: loaded once per region, then stepped once per pushed page.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			first_q <= first_pn;
			limit_q <= limit_pn;
		end else if (ctrl.step) begin
			first_q <= first_q + (pfs_pkg::PN_W+1)'(1);
		end
	end

	assign stat.more = first_q < {1'b0, limit_q};
	assign stat.addr = {first_q[pfs_pkg::PN_W-1:0], {pfs_pkg::PAGE_SHIFT{1'b0}}};

endmodule

// File: sim/page_frame_free_stack_tb.sv
module page_frame_free_stack_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_ITEMS  = 1530;
	localparam int DRAIN_CYCLES  = 12;

	// One command beat as it goes into the allocator.
	typedef struct {
		logic [1:0]                 cmd;
		logic [pfs_pkg::ADDR_W-1:0] base;
		logic [pfs_pkg::ADDR_W-1:0] length;
		logic                       usable;
		logic [pfs_pkg::ADDR_W-1:0] addr;
	} page_cmd_t;

	// One result beat as it comes back.
	typedef struct {
		logic [pfs_pkg::ADDR_W-1:0]  page_addr;
		logic [pfs_pkg::COUNT_W-1:0] free_count;
		logic [1:0]                  status;
	} page_rsp_t;

	logic clk;
	logic arst_n;

	pfs_req_if req();
	pfs_rsp_if rsp();

	page_frame_free_stack uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// Shadow copy of the free page pool.
	logic [pfs_pkg::ADDR_W-1:0] pool_pages [pfs_pkg::STACK_DEPTH];
	int unsigned                pool_depth;

	page_cmd_t   pending_cmds [$];
	page_rsp_t   expected_rsp [$];
	page_cmd_t   sent_beat;
	page_cmd_t   next_beat;
	page_rsp_t   want;
	int unsigned send_gap;
	int unsigned send_calm;
	int unsigned recv_gap;
	int unsigned recv_calm;
	int unsigned error_count;
	int unsigned cycle_count;

	always #6 clk = ~clk;

	function automatic logic [pfs_pkg::ADDR_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Idle length for either side: mostly none or short, a few long, and now
	// and then a calm stretch with no idling at all.
	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if (roll < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Apply one command to the shadow pool and return the result it must give.
	function automatic page_rsp_t apply_page_cmd(input page_cmd_t c);
		page_rsp_t                  r;
		logic [pfs_pkg::ADDR_W:0]   span_end;
		logic [pfs_pkg::PN_W:0]     first_pn;
		logic [pfs_pkg::PN_W:0]     limit_pn;
		r.page_addr = '0;
		r.status    = pfs_pkg::STAT_OK;
		case (c.cmd)
			pfs_pkg::CMD_ADD: begin
				if (c.usable) begin
					// The region end saturates at the top of the address space.
					span_end = {1'b0, c.base} + {1'b0, c.length};
					if (span_end[pfs_pkg::ADDR_W])
						span_end = {1'b0, {pfs_pkg::ADDR_W{1'b1}}};
					// Round the base up and the end down to whole pages.
					first_pn = {1'b0, c.base[pfs_pkg::ADDR_W-1:pfs_pkg::PAGE_SHIFT]}
						+ (pfs_pkg::PN_W+1)'(c.base[pfs_pkg::PAGE_SHIFT-1:0] != '0);
					limit_pn = {1'b0, span_end[pfs_pkg::ADDR_W-1:pfs_pkg::PAGE_SHIFT]};
					while (first_pn < limit_pn && r.status == pfs_pkg::STAT_OK) begin
						if (pool_depth == pfs_pkg::STACK_DEPTH) begin
							r.status = pfs_pkg::STAT_FULL;
						end else begin
							pool_pages[pool_depth] =
								{first_pn[pfs_pkg::PN_W-1:0], {pfs_pkg::PAGE_SHIFT{1'b0}}};
							pool_depth++;
							first_pn++;
						end
					end
				end
			end
			pfs_pkg::CMD_ALLOC: begin
				if (pool_depth == 0) begin
					r.status = pfs_pkg::STAT_EMPTY;
				end else begin
					pool_depth--;
					r.page_addr = pool_pages[pool_depth];
				end
			end
			pfs_pkg::CMD_FREE: begin
				if (pool_depth == pfs_pkg::STACK_DEPTH) begin
					r.status = pfs_pkg::STAT_FULL;
				end else begin
					pool_pages[pool_depth] = c.addr;
					pool_depth++;
				end
			end
			default: begin
			end
		endcase
		r.free_count = pfs_pkg::COUNT_W'(pool_depth);
		return r;
	endfunction

	task automatic push_cmd(input logic [1:0] cmd, input logic [pfs_pkg::ADDR_W-1:0] base,
			input logic [pfs_pkg::ADDR_W-1:0] length, input logic usable,
			input logic [pfs_pkg::ADDR_W-1:0] addr);
		page_cmd_t c;
		c.cmd    = cmd;
		c.base   = base;
		c.length = length;
		c.usable = usable;
		c.addr   = addr;
		pending_cmds.push_back(c);
	endtask

	// Command driver: predicts each accepted beat, then idles or presents the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid         <= 1'b0;
			req.cmd           <= pfs_pkg::CMD_COUNT;
			req.region_base   <= '0;
			req.region_length <= '0;
			req.region_usable <= 1'b0;
			req.free_addr     <= '0;
			send_gap = pick_gap(send_calm);
		end else if (!req.valid || req.ready) begin
			if (req.valid) begin
				sent_beat.cmd    = req.cmd;
				sent_beat.base   = req.region_base;
				sent_beat.length = req.region_length;
				sent_beat.usable = req.region_usable;
				sent_beat.addr   = req.free_addr;
				expected_rsp.push_back(apply_page_cmd(sent_beat));
				send_gap = pick_gap(send_calm);
			end
			if (send_gap > 0) begin
				send_gap--;
				req.valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				next_beat = pending_cmds.pop_front();
				req.valid         <= 1'b1;
				req.cmd           <= next_beat.cmd;
				req.region_base   <= next_beat.base;
				req.region_length <= next_beat.length;
				req.region_usable <= next_beat.usable;
				req.free_addr     <= next_beat.addr;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Result monitor: compares each accepted beat with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_gap = pick_gap(recv_calm);
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: result with nothing pending: page_addr=%h free_count=%0d status=%0d",
						$time, rsp.page_addr, rsp.free_count, rsp.status);
					error_count++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.page_addr !== want.page_addr) begin
						$display("%0t: page_addr expected %h actual %h",
							$time, want.page_addr, rsp.page_addr);
						error_count++;
					end
					if (rsp.free_count !== want.free_count) begin
						$display("%0t: free_count expected %0d actual %0d",
							$time, want.free_count, rsp.free_count);
						error_count++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
						error_count++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				recv_gap = pick_gap(recv_calm);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("page_frame_free_stack verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned                roll;
		int unsigned                pages;
		int unsigned                counted;
		logic [pfs_pkg::ADDR_W-1:0] b;
		logic [pfs_pkg::ADDR_W-1:0] l;

		clk               = 1'b0;
		arst_n            = 1'b0;
		req.valid         = 1'b0;
		req.cmd           = pfs_pkg::CMD_COUNT;
		req.region_base   = '0;
		req.region_length = '0;
		req.region_usable = 1'b0;
		req.free_addr     = '0;
		rsp.ready         = 1'b0;
		pool_depth        = 0;
		error_count       = 0;
		cycle_count       = 0;
		send_calm         = 0;
		recv_calm         = 0;
		counted           = 0;

		// Directed: empty pool, region corner cases, unchecked frees, overflow.
		push_cmd(pfs_pkg::CMD_ALLOC, rand64(), rand64(), 1'b1, rand64());
		push_cmd(pfs_pkg::CMD_COUNT, rand64(), rand64(), 1'b0, rand64());
		push_cmd(pfs_pkg::CMD_ADD, '0, '1, 1'b0, rand64());
		push_cmd(pfs_pkg::CMD_ADD, 64'h1001, 64'hFFE, 1'b1, rand64());
		push_cmd(pfs_pkg::CMD_ADD, '0, '0, 1'b1, rand64());
		push_cmd(pfs_pkg::CMD_ADD, 64'h1000, 64'h3000, 1'b1, rand64());
		push_cmd(pfs_pkg::CMD_ADD, 64'h7_0000_0123, 64'h5000, 1'b1, rand64());
		push_cmd(pfs_pkg::CMD_ADD, 64'hFFFF_FFFF_FFFF_C000, '1, 1'b1, rand64());
		push_cmd(pfs_pkg::CMD_ADD, 64'hFFFF_FFFF_FFFF_F001, 64'h800, 1'b1, rand64());
		push_cmd(pfs_pkg::CMD_FREE, rand64(), rand64(), 1'b1, '1);
		push_cmd(pfs_pkg::CMD_FREE, rand64(), rand64(), 1'b0, '0);
		push_cmd(pfs_pkg::CMD_FREE, rand64(), rand64(), 1'b1, 64'h1234_5678_9ABC_DEF1);
		for (int i = 0; i < 3; i++)
			push_cmd(pfs_pkg::CMD_ALLOC, rand64(), rand64(), 1'b0, rand64());
		push_cmd(pfs_pkg::CMD_COUNT, rand64(), rand64(), 1'b1, rand64());
		push_cmd(pfs_pkg::CMD_ADD, 64'h4000_0000, 64'h0100_0000, 1'b1, rand64());
		push_cmd(pfs_pkg::CMD_FREE, rand64(), rand64(), 1'b0, 64'h5000);
		push_cmd(pfs_pkg::CMD_COUNT, rand64(), rand64(), 1'b0, rand64());
		for (int i = 0; i < 2; i++)
			push_cmd(pfs_pkg::CMD_ALLOC, rand64(), rand64(), 1'b1, rand64());
		push_cmd(pfs_pkg::CMD_ADD, 64'h8000_0000, 64'h5000, 1'b1, rand64());

		// Random traffic, weighted toward allocation so the pool keeps moving.
		while (counted < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			counted++;
			if (roll < 42) begin
				push_cmd(pfs_pkg::CMD_ALLOC, rand64(), rand64(), 1'($urandom), rand64());
			end else if (roll < 55) begin
				b = rand64();
				if ($urandom_range(0, 1))
					b[pfs_pkg::PAGE_SHIFT-1:0] = '0;
				push_cmd(pfs_pkg::CMD_FREE, rand64(), rand64(), 1'($urandom), b);
			end else if (roll < 63) begin
				push_cmd(pfs_pkg::CMD_COUNT, rand64(), rand64(), 1'($urandom), rand64());
			end else if (roll < 85) begin
				// Small usable region, sometimes page aligned.
				pages = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 64)
					: $urandom_range(0, 3);
				b = rand64();
				if ($urandom_range(0, 1))
					b = b >> $urandom_range(0, 63);
				if ($urandom_range(0, 1))
					b[pfs_pkg::PAGE_SHIFT-1:0] = '0;
				l = pfs_pkg::ADDR_W'(pages) * pfs_pkg::PAGE_BYTES
					+ $urandom_range(0, pfs_pkg::PAGE_BYTES - 1);
				push_cmd(pfs_pkg::CMD_ADD, b, l, 1'b1, rand64());
			end else if (roll < 93) begin
				// Unusable region: no effect on the pool.
				push_cmd(pfs_pkg::CMD_ADD, rand64(), rand64(), 1'b0, rand64());
			end else if (roll < 97) begin
				// Region of random size, often far bigger than the free room.
				push_cmd(pfs_pkg::CMD_ADD, rand64() >> $urandom_range(0, 63), rand64(), 1'b1,
					rand64());
			end else begin
				// Region at the top of the address space whose end saturates.
				b = '1;
				b = b - $urandom_range(0, 20 * pfs_pkg::PAGE_BYTES);
				push_cmd(pfs_pkg::CMD_ADD, b, rand64(), 1'b1, rand64());
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every beat to go out and every result to come back.
		do
			@(posedge clk);
		while (pending_cmds.size() != 0 || req.valid || expected_rsp.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_rsp.size() == 0)
			$display("page_frame_free_stack verification clean");
		else
			$display("page_frame_free_stack verification failed");
		$finish;
	end

endmodule

// File: files.f
hdl/pfs_pkg.sv
hdl/pfs_if.sv
hdl/pfs_ram.sv
hdl/pfs_region_walk.sv
hdl/page_frame_free_stack.sv
sim/page_frame_free_stack_tb.sv
